[src/gpc_pkg.sv]
// Shared types and constants of the GPIO pad controller.
package gpc_pkg;

	localparam int NUM_CHUNKS_DEF     = 7;
	localparam int PINS_PER_CHUNK_DEF = 15;
	localparam int NUM_IRQ_LINES_DEF  = 16;

	// Pin index as carried between front and back: wide enough for up to 1024 pins.
	localparam int PIN_MAX_W = 10;

	localparam logic [15:0] ADDR_STATUS  = 16'h0300;
	localparam logic [15:0] ADDR_MASK    = 16'h0380;
	localparam logic [15:0] ADDR_PINS    = 16'h4400;
	localparam int          CHUNK_SHIFT  = 10;   // chunk stride 0x400
	localparam int          SLOT_SHIFT   = 3;    // pin stride 0x8
	localparam logic [2:0]  SUB_CTL0     = 3'd0;
	localparam logic [2:0]  SUB_CTL1     = 3'd4;

	localparam int          BIT_RX       = 0;
	localparam int          BIT_TX       = 1;
	localparam int          BIT_INV      = 6;
	localparam logic [2:0]  GPIOCFG_TX0  = 3'd0;
	localparam logic [2:0]  GPIOCFG_TX1  = 3'd1;

	localparam logic [1:0]  OP_READ      = 2'd0;
	localparam logic [1:0]  OP_WRITE     = 2'd1;
	localparam logic [1:0]  OP_PAD       = 2'd2;

	localparam logic [2:0]  TRIG_FALL    = 3'd1;
	localparam logic [2:0]  TRIG_RISE    = 3'd2;
	localparam logic [2:0]  TRIG_BOTH    = 3'd3;
	localparam logic [2:0]  TRIG_LEVEL   = 3'd4;

	typedef enum logic [3:0] {
		K_NOP,
		K_ERR,
		K_RD_STAT,
		K_WR_STAT,
		K_RD_MASK,
		K_WR_MASK,
		K_RD_PIN,
		K_WR_PIN,
		K_PAD
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [PIN_MAX_W-1:0]  pin;
		logic                  second;
		logic [31:0]           data;
		logic                  level;
	} req_t;

	typedef enum logic {
		B_IDLE,
		B_EX
	} bstate_t;

endpackage

[src/gpc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gpc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 105,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/gpc_front.sv]
// Front end: accept requests, decode the bus address, queue decoded requests.
module gpc_front import gpc_pkg::*; #(
	parameter int NUM_CHUNKS     = NUM_CHUNKS_DEF,
	parameter int PINS_PER_CHUNK = PINS_PER_CHUNK_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [15:0] address,
	input  logic [31:0] write_data,
	input  logic [6:0]  pad_pin,
	input  logic        pad_level,
	output logic        q_valid,
	output req_t        q_req,
	input  logic        q_pop
);

	localparam int NUM_PINS = NUM_CHUNKS * PINS_PER_CHUNK;

	logic [15:0]          off;
	logic [5:0]           chunk;
	logic [6:0]           slot;
	logic [2:0]           sub;
	logic                 is_pin;
	logic [12:0]          pin_sum;
	req_t                 dec;
	req_t                 fifo_q [2];
	logic                 wp_q;
	logic                 rp_q;
	logic [1:0]           cnt_q;
	logic                 push;

	always_comb begin
		off     = address - ADDR_PINS;
		chunk   = off[15:CHUNK_SHIFT];
		slot    = off[CHUNK_SHIFT-1:SLOT_SHIFT];
		sub     = off[SLOT_SHIFT-1:0];
		is_pin  = (address >= ADDR_PINS) && (32'(chunk) < NUM_CHUNKS) &&
			(32'(slot) < PINS_PER_CHUNK) && (sub == SUB_CTL0 || sub == SUB_CTL1);
		pin_sum = 13'(chunk) * 13'(PINS_PER_CHUNK) + 13'(slot);

		dec.kind   = K_NOP;
		dec.pin    = pin_sum[PIN_MAX_W-1:0];
		dec.second = (sub == SUB_CTL1);
		dec.data   = write_data;
		dec.level  = pad_level;
		unique case (opcode) inside
			OP_READ, OP_WRITE: begin
				if (address == ADDR_STATUS) begin
					dec.kind = (opcode == OP_READ) ? K_RD_STAT : K_WR_STAT;
				end else if (address == ADDR_MASK) begin
					dec.kind = (opcode == OP_READ) ? K_RD_MASK : K_WR_MASK;
				end else if (is_pin) begin
					dec.kind = (opcode == OP_READ) ? K_RD_PIN : K_WR_PIN;
				end else begin
					dec.kind = K_ERR;
				end
			end
			OP_PAD: begin
				dec.pin  = PIN_MAX_W'(pad_pin);
				dec.kind = (32'(pad_pin) < NUM_PINS) ? K_PAD : K_NOP;
			end
			default: dec.kind = K_NOP;
		endcase
	end

	// Two-entry queue between decode and execution
	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

[src/gpc_back.sv]
// Back end: read pin words, apply the request, update interrupt state, hold the result.
module gpc_back import gpc_pkg::*; #(
	parameter int NUM_CHUNKS     = NUM_CHUNKS_DEF,
	parameter int PINS_PER_CHUNK = PINS_PER_CHUNK_DEF,
	parameter int NUM_IRQ_LINES  = NUM_IRQ_LINES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  req_t        q_req,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic        bus_error,
	output logic        irq,
	output logic        drive_changed,
	output logic [6:0]  drive_pin,
	output logic        drive_level
);

	localparam int NUM_PINS = NUM_CHUNKS * PINS_PER_CHUNK;
	localparam int PIN_W    = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
	localparam int NL       = NUM_IRQ_LINES;

	function automatic logic [NL-1:0] line_bit(logic [31:0] c0);
		logic [NL-1:0] b;
		b = '0;
		if (32'(c0[31:28]) < NL) begin
			b[c0[31:28]] = 1'b1;
		end
		return b;
	endfunction

	bstate_t         state_q;
	bstate_t         state_d;
	req_t            cur_q;
	logic [NUM_PINS-1:0] vld_q;
	logic [NL-1:0]   status_q;
	logic [NL-1:0]   mask_q;
	logic [NL-1:0]   lact_q;
	logic [PIN_W-1:0] rd_pin;
	logic [PIN_W-1:0] pin_i;
	logic [31:0]     rd0;
	logic [31:0]     rd1;
	logic [31:0]     c0;
	logic [31:0]     c1;
	logic [31:0]     n0;
	logic [31:0]     n1;
	logic [NL-1:0]   la_n;
	logic [NL-1:0]   st_n;
	logic [NL-1:0]   mk_n;
	logic            we;
	logic            commit;
	logic            newrx;
	logic            fire;
	logic [31:0]     r_data;
	logic            r_err;
	logic            r_dchg;
	logic            r_dlvl;

	logic            out_valid_q;
	logic [31:0]     read_data_q;
	logic            bus_error_q;
	logic            irq_q;
	logic            drive_changed_q;
	logic [6:0]      drive_pin_q;
	logic            drive_level_q;

	assign rd_pin = q_req.pin[PIN_W-1:0];
	assign pin_i  = cur_q.pin[PIN_W-1:0];

	gpc_ram #(.WIDTH(32), .DEPTH(NUM_PINS)) u_ctl0 (
		.clk(clk), .we(we), .waddr(pin_i), .wdata(n0),
		.re(q_pop), .raddr(rd_pin), .rdata(rd0)
	);

	gpc_ram #(.WIDTH(32), .DEPTH(NUM_PINS)) u_ctl1 (
		.clk(clk), .we(we), .waddr(pin_i), .wdata(n1),
		.re(q_pop), .raddr(rd_pin), .rdata(rd1)
	);

	assign commit = (state_q == B_EX) && (!out_valid_q || out_ready);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (q_valid) state_d = B_EX;
			B_EX:   if (commit) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		q_pop = (state_q == B_IDLE) && q_valid;
	end

	// Execute the request held in cur_q
	always_comb begin
		c0     = vld_q[pin_i] ? rd0 : 32'h0;
		c1     = vld_q[pin_i] ? rd1 : 32'h0;
		n0     = c0;
		n1     = c1;
		la_n   = lact_q;
		st_n   = status_q;
		mk_n   = mask_q;
		we     = 1'b0;
		fire   = 1'b0;
		newrx  = cur_q.level ^ c1[BIT_INV];
		r_data = 32'h0;
		r_err  = 1'b0;
		r_dchg = 1'b0;
		r_dlvl = 1'b0;
		case (cur_q.kind)
			K_RD_STAT: r_data = 32'(status_q);
			K_WR_STAT: st_n = status_q & ~cur_q.data[NL-1:0];
			K_RD_MASK: r_data = 32'(mask_q);
			K_WR_MASK: mk_n = cur_q.data[NL-1:0];
			K_RD_PIN:  r_data = cur_q.second ? c1 : c0;
			K_ERR:     r_err = 1'b1;
			K_WR_PIN: begin
				we = 1'b1;
				if (c1[2:0] == TRIG_LEVEL) begin
					la_n = la_n & ~line_bit(c0);
				end
				if (cur_q.second) begin
					n1 = cur_q.data;
					n0[BIT_RX] = c0[BIT_RX] ^ (c1[BIT_INV] ^ cur_q.data[BIT_INV]);
				end else begin
					n0 = {cur_q.data[31:1], c0[BIT_RX]};
					if ((c0[BIT_TX] != cur_q.data[BIT_TX]) &&
						(cur_q.data[10:8] == GPIOCFG_TX0 ||
						 cur_q.data[10:8] == GPIOCFG_TX1)) begin
						r_dchg = 1'b1;
						r_dlvl = cur_q.data[BIT_TX];
					end
				end
				if (n0[BIT_RX] && n1[2:0] == TRIG_LEVEL) begin
					la_n = la_n | line_bit(n0);
				end
			end
			K_PAD: begin
				we = 1'b1;
				n0[BIT_RX] = newrx;
				if (c1[2:0] == TRIG_LEVEL) begin
					la_n = la_n & ~line_bit(c0);
					if (newrx) begin
						la_n = la_n | line_bit(c0);
					end
				end
				case (c1[2:0])
					TRIG_FALL: fire = c0[BIT_RX] && !newrx;
					TRIG_RISE: fire = !c0[BIT_RX] && newrx;
					TRIG_BOTH: fire = c0[BIT_RX] != newrx;
					default:   fire = 1'b0;
				endcase
				if (fire) begin
					st_n = st_n | line_bit(c0);
				end
			end
			default: ;
		endcase
		st_n = st_n | la_n;
		we   = we && commit;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_req;
		end
		if (commit) begin
			read_data_q     <= r_data;
			bus_error_q     <= r_err;
			irq_q           <= |(st_n & mk_n);
			drive_changed_q <= r_dchg;
			drive_pin_q     <= r_dchg ? 7'(pin_i) : 7'd0;
			drive_level_q   <= r_dlvl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			vld_q       <= '0;
			status_q    <= '0;
			mask_q      <= '0;
			lact_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (we) begin
				vld_q[pin_i] <= 1'b1;
			end
			if (commit) begin
				status_q    <= st_n;
				mask_q      <= mk_n;
				lact_q      <= la_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign read_data     = read_data_q;
	assign bus_error     = bus_error_q;
	assign irq           = irq_q;
	assign drive_changed = drive_changed_q;
	assign drive_pin     = drive_pin_q;
	assign drive_level   = drive_level_q;

endmodule

[src/gpio_pad_controller_irq_lines.sv]
// Top level of the GPIO pad controller with edge and level interrupt lines.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------------
//   in      | to block  | in_valid / in_ready   | opcode, address, write_data, pad_pin, pad_level
//   out     | from block| out_valid / out_ready | read_data, bus_error, irq, drive_changed,
//           |           |                       | drive_pin, drive_level
//
// In the back end, the idle state reads the pin's CTL0/CTL1 words from the registered-read
// RAMs and the execute state applies the request and writes them back. Because of that RAM
// read-modify-write, the back end takes no new request from the queue until the current one
// has been written back. Reset clears the queue, the interrupt status, mask and level
// state and per-pin valid bits, so every pin word reads as zero until written; no clearing
// pass is needed. A two-entry queue between decode and execution lets the input keep
// accepting while a result waits in the output register; a stalled output holds the back
// end in execute.
module gpio_pad_controller_irq_lines import gpc_pkg::*; #(
	parameter int NUM_CHUNKS     = NUM_CHUNKS_DEF,
	parameter int PINS_PER_CHUNK = PINS_PER_CHUNK_DEF,
	parameter int NUM_IRQ_LINES  = NUM_IRQ_LINES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [15:0] address,
	input  logic [31:0] write_data,
	input  logic [6:0]  pad_pin,
	input  logic        pad_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic        bus_error,
	output logic        irq,
	output logic        drive_changed,
	output logic [6:0]  drive_pin,
	output logic        drive_level
);

	logic q_valid;
	logic q_pop;
	req_t q_req;

	// Decode and queue requests
	gpc_front #(
		.NUM_CHUNKS(NUM_CHUNKS),
		.PINS_PER_CHUNK(PINS_PER_CHUNK)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .address(address), .write_data(write_data),
		.pad_pin(pad_pin), .pad_level(pad_level),
		.q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
	);

	// Execute requests against pin words and interrupt state
	gpc_back #(
		.NUM_CHUNKS(NUM_CHUNKS),
		.PINS_PER_CHUNK(PINS_PER_CHUNK),
		.NUM_IRQ_LINES(NUM_IRQ_LINES)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_req(q_req), .q_pop(q_pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_data(read_data), .bus_error(bus_error), .irq(irq),
		.drive_changed(drive_changed), .drive_pin(drive_pin),
		.drive_level(drive_level)
	);

endmodule

[src/gpc_checker.sv]
// Port-level checks of the GPIO pad controller, bound to the top level.
module gpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] read_data,
	input logic        bus_error,
	input logic        drive_changed,
	input logic [6:0]  drive_pin,
	input logic        drive_level
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data))
		else $error("result dropped or changed while stalled");

	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bus_error |-> read_data == 32'h0)
		else $error("bus error with nonzero read data");

	a_err_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bus_error |-> !drive_changed)
		else $error("bus error with drive change");

	a_drive_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !drive_changed |-> drive_pin == 7'd0 && !drive_level)
		else $error("drive fields set without drive change");

endmodule

bind gpio_pad_controller_irq_lines gpc_checker u_gpc_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.read_data(read_data), .bus_error(bus_error), .drive_changed(drive_changed),
	.drive_pin(drive_pin), .drive_level(drive_level)
);
